/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the clipper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SWC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SWC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/swc_pkg.sv */
// ----------------------------------------------------------------------------
// swc_pkg
// Constants, register indexes and helpers of the segment window clipper.
// ----------------------------------------------------------------------------
package swc_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COORD_BITS_MAX = 16;
    localparam int CFG_IDX_BITS   = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 3'd3;

    // Window register reset values.
    localparam int X_MIN_RST = 150;
    localparam int X_MAX_RST = 250;
    localparam int Y_MIN_RST = 150;
    localparam int Y_MAX_RST = 350;

    // Window edges in visiting order.
    localparam int SIDE_TOP    = 0;
    localparam int SIDE_BOTTOM = 1;
    localparam int SIDE_LEFT   = 2;
    localparam int SIDE_RIGHT  = 3;

    // Window slot order inside the packed window vector.
    localparam int WIN_X_MIN = 0;
    localparam int WIN_X_MAX = 1;
    localparam int WIN_Y_MIN = 2;
    localparam int WIN_Y_MAX = 3;

    typedef logic [COORD_BITS_MAX-1:0] t_coord_max;

    function automatic logic swc_in_window(t_coord_max x, t_coord_max y,
                                           t_coord_max x_min, t_coord_max x_max,
                                           t_coord_max y_min, t_coord_max y_max);
        return (x >= x_min) && (x <= x_max) && (y >= y_min) && (y <= y_max);
    endfunction

endpackage

/* hw/rtl/swc_edge.sv */
// ----------------------------------------------------------------------------
// swc_edge
// Pipelined clip of a segment against one window edge: products, magnitude,
// one quotient bit per stage, then the hit test and endpoint replacement.
// ----------------------------------------------------------------------------
module swc_edge #(
    parameter int COORD_BITS = swc_pkg::COORD_BITS_DEF,
    parameter int SIDE       = swc_pkg::SIDE_TOP
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [3:0][COORD_BITS-1:0]    i_win,
    input  logic                          i_valid,
    input  logic [3:0][COORD_BITS-1:0]    i_seg,
    output logic                          o_valid,
    output logic [3:0][COORD_BITS-1:0]    o_seg
);
    import swc_pkg::*;

    localparam int  N     = COORD_BITS;
    localparam bit  HORIZ = (SIDE == SIDE_TOP) || (SIDE == SIDE_BOTTOM);

    typedef logic [N-1:0] t_coord;

    // Edge geometry. The "along" axis runs with the edge, "across" is fixed.
    t_coord w, e_lo, e_hi;
    assign w    = (SIDE == SIDE_TOP)    ? i_win[WIN_Y_MIN] :
                  (SIDE == SIDE_BOTTOM) ? i_win[WIN_Y_MAX] :
                  (SIDE == SIDE_LEFT)   ? i_win[WIN_X_MIN] : i_win[WIN_X_MAX];
    assign e_lo = HORIZ ? i_win[WIN_X_MIN] : i_win[WIN_Y_MIN];
    assign e_hi = HORIZ ? i_win[WIN_X_MAX] : i_win[WIN_Y_MAX];

    // Stage 1: the two cross products and the across distance.
    t_coord a1, c1, a2, c2, n_d;
    logic signed [N:0]     dw1, dw2;
    logic signed [2*N+1:0] n_p1, n_p2;
    assign a1  = HORIZ ? i_seg[0] : i_seg[1];
    assign c1  = HORIZ ? i_seg[1] : i_seg[0];
    assign a2  = HORIZ ? i_seg[2] : i_seg[3];
    assign c2  = HORIZ ? i_seg[3] : i_seg[2];
    assign dw2 = $signed({1'b0, w}) - $signed({1'b0, c2});
    assign dw1 = $signed({1'b0, w}) - $signed({1'b0, c1});
    assign n_p1 = (2*N+2)'($signed({1'b0, a1}) * dw2);
    assign n_p2 = (2*N+2)'($signed({1'b0, a2}) * dw1);
    assign n_d  = (c2 > c1) ? t_coord'(c2 - c1) : t_coord'(c1 - c2);

    logic                   r1_valid;
    logic [3:0][N-1:0]      r1_seg;
    logic signed [2*N+1:0]  r1_p1, r1_p2;
    t_coord                 r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_seg <= i_seg;
            r1_p1  <= n_p1;
            r1_p2  <= n_p2;
            r1_d   <= n_d;
        end
    end

    // Stage 2: numerator magnitude and the quotient range check.
    logic signed [2*N+1:0] diff;
    logic [2*N+1:0]        mag_full;
    logic [2*N:0]          n_mag;
    logic                  n_bad;
    assign diff     = r1_p1 - r1_p2;
    assign mag_full = diff[2*N+1] ? (2*N+2)'(-diff) : (2*N+2)'(diff);
    assign n_mag    = mag_full[2*N:0];
    assign n_bad    = (n_mag[2*N:N] >= {1'b0, r1_d}) || (r1_d == '0) || (e_lo == e_hi);

    logic              r_v   [0:N];
    logic [3:0][N-1:0] r_sg  [0:N];
    logic              r_bad [0:N];
    t_coord            r_d   [0:N];
    t_coord            r_rem [0:N];
    t_coord            r_lo  [0:N];
    t_coord            r_q   [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r1_valid;
        end
        if (i_en) begin
            r_sg[0]  <= r1_seg;
            r_bad[0] <= n_bad;
            r_d[0]   <= r1_d;
            r_rem[0] <= n_mag[2*N-1:N];
            r_lo[0]  <= n_mag[N-1:0];
            r_q[0]   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first.
    for (genvar j = 0; j < N; j++) begin : g_div
        logic [N:0] t;
        logic       ge;
        t_coord     n_rem;
        assign t     = {r_rem[j], r_lo[j][N-1]};
        assign ge    = t >= {1'b0, r_d[j]};
        assign n_rem = ge ? t_coord'(t - {1'b0, r_d[j]}) : t[N-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
            if (i_en) begin
                r_sg[j+1]  <= r_sg[j];
                r_bad[j+1] <= r_bad[j];
                r_d[j+1]   <= r_d[j];
                r_rem[j+1] <= n_rem;
                r_lo[j+1]  <= {r_lo[j][N-2:0], 1'b0};
                r_q[j+1]   <= {r_q[j][N-2:0], ge};
            end
        end
    end

    // Final stage: hit test against both bounding boxes, then replace.
    logic [3:0][N-1:0] sg, n_seg;
    t_coord along, fa1, fa2, fc1, fc2, a_min, a_max, c_min, c_max, el_min, el_max;
    t_coord px, py;
    logic   s_in, e_in, hit, beyond, move_start;

    assign sg    = r_sg[N];
    assign along = r_q[N];
    assign fa1   = HORIZ ? sg[0] : sg[1];
    assign fc1   = HORIZ ? sg[1] : sg[0];
    assign fa2   = HORIZ ? sg[2] : sg[3];
    assign fc2   = HORIZ ? sg[3] : sg[2];
    assign a_min  = (fa1 < fa2) ? fa1 : fa2;
    assign a_max  = (fa1 > fa2) ? fa1 : fa2;
    assign c_min  = (fc1 < fc2) ? fc1 : fc2;
    assign c_max  = (fc1 > fc2) ? fc1 : fc2;
    assign el_min = (e_lo < e_hi) ? e_lo : e_hi;
    assign el_max = (e_lo > e_hi) ? e_lo : e_hi;

    assign s_in = swc_in_window(t_coord_max'(sg[0]), t_coord_max'(sg[1]),
                                t_coord_max'(i_win[WIN_X_MIN]),
                                t_coord_max'(i_win[WIN_X_MAX]),
                                t_coord_max'(i_win[WIN_Y_MIN]),
                                t_coord_max'(i_win[WIN_Y_MAX]));
    assign e_in = swc_in_window(t_coord_max'(sg[2]), t_coord_max'(sg[3]),
                                t_coord_max'(i_win[WIN_X_MIN]),
                                t_coord_max'(i_win[WIN_X_MAX]),
                                t_coord_max'(i_win[WIN_Y_MIN]),
                                t_coord_max'(i_win[WIN_Y_MAX]));

    assign hit = !r_bad[N] && (along >= el_min) && (along <= el_max) &&
                 (along >= a_min) && (along <= a_max) && (w >= c_min) && (w <= c_max);

    assign beyond = (SIDE == SIDE_TOP)    ? (sg[1] < i_win[WIN_Y_MIN]) :
                    (SIDE == SIDE_BOTTOM) ? (sg[1] > i_win[WIN_Y_MAX]) :
                    (SIDE == SIDE_LEFT)   ? (sg[0] < i_win[WIN_X_MIN]) :
                                            (sg[0] > i_win[WIN_X_MAX]);
    assign move_start = (!s_in && e_in) ? 1'b1 : (s_in && !e_in) ? 1'b0 : beyond;
    assign px = HORIZ ? along : w;
    assign py = HORIZ ? w : along;

    always_comb begin
        n_seg = sg;
        if (!(s_in && e_in) && hit) begin
            if (move_start) begin
                n_seg[0] = px;
                n_seg[1] = py;
            end else begin
                n_seg[2] = px;
                n_seg[3] = py;
            end
        end
    end

    logic              r_out_valid;
    logic [3:0][N-1:0] r_out_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_v[N];
        end
        if (i_en) begin
            r_out_seg <= n_seg;
        end
    end

    assign o_valid = r_out_valid;
    assign o_seg   = r_out_seg;

endmodule

/* hw/rtl/segment_window_clipper.sv */
// ----------------------------------------------------------------------------
// segment_window_clipper
// Clips one line segment per beat against a rectangular window.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | i_valid / o_stall         | start_x/y, end_x/y
//  output  | out       | o_valid / i_stall         | clipped_*, visible
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One segment beat is accepted every cycle while o_stall is low. It passes through
//  the edge stages in turn, one per window edge, each built around a restoring divider.
//  Reset is synchronous and clears the valid bits and loads the window registers.
//  When the output beat is held by i_stall the whole pipeline freezes and o_stall
//  rises in the same cycle, so no beat is lost or repeated.
//  Configuration writes are always ready; indexes 0 to 3 go to the window registers.
//
// The window edges are processed in the order top, bottom, left, right. Each
// edge stage works out the integer intersection of the current segment with
// that edge and moves the proper endpoint onto it. A last register stage
// forms the visible flag and zeroes the endpoints of an invisible segment.
module segment_window_clipper #(
    parameter int COORD_BITS = swc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Segment input.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_BITS-1:0]             i_start_x,
    input  logic [COORD_BITS-1:0]             i_start_y,
    input  logic [COORD_BITS-1:0]             i_end_x,
    input  logic [COORD_BITS-1:0]             i_end_y,
    // Clipped output.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [COORD_BITS-1:0]             o_clipped_start_x,
    output logic [COORD_BITS-1:0]             o_clipped_start_y,
    output logic [COORD_BITS-1:0]             o_clipped_end_x,
    output logic [COORD_BITS-1:0]             o_clipped_end_y,
    output logic                              o_visible,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0]             i_cfg_data
);
    import swc_pkg::*;

    `include "assert_macros.svh"

    localparam int N = COORD_BITS;

    // Window registers, packed in the order x_min, x_max, y_min, y_max.
    logic [3:0][N-1:0] r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[WIN_X_MIN] <= N'(X_MIN_RST);
            r_win[WIN_X_MAX] <= N'(X_MAX_RST);
            r_win[WIN_Y_MIN] <= N'(Y_MIN_RST);
            r_win[WIN_Y_MAX] <= N'(Y_MAX_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_X_MIN: r_win[WIN_X_MIN] <= i_cfg_data;
                REG_X_MAX: r_win[WIN_X_MAX] <= i_cfg_data;
                REG_Y_MIN: r_win[WIN_Y_MIN] <= i_cfg_data;
                REG_Y_MAX: r_win[WIN_Y_MAX] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The pipeline advances whenever the output register is free or drained.
    logic r_o_valid;
    logic en;
    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;

    // Chain of edge stages, one per window edge.
    logic              ch_valid [0:4];
    logic [3:0][N-1:0] ch_seg   [0:4];

    assign ch_valid[0] = i_valid;
    assign ch_seg[0]   = {i_end_y, i_end_x, i_start_y, i_start_x};

    for (genvar s = 0; s < 4; s++) begin : g_edge
        swc_edge #(
            .COORD_BITS (COORD_BITS),
            .SIDE       (s)
        ) u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_win   (r_win),
            .i_valid (ch_valid[s]),
            .i_seg   (ch_seg[s]),
            .o_valid (ch_valid[s+1]),
            .o_seg   (ch_seg[s+1])
        );
    end

    // Output stage: visibility and zeroing of a rejected segment.
    logic [3:0][N-1:0] fs;
    logic              n_vis;
    assign fs = ch_seg[4];
    assign n_vis =
        swc_in_window(t_coord_max'(fs[0]), t_coord_max'(fs[1]),
                      t_coord_max'(r_win[WIN_X_MIN]), t_coord_max'(r_win[WIN_X_MAX]),
                      t_coord_max'(r_win[WIN_Y_MIN]), t_coord_max'(r_win[WIN_Y_MAX])) ||
        swc_in_window(t_coord_max'(fs[2]), t_coord_max'(fs[3]),
                      t_coord_max'(r_win[WIN_X_MIN]), t_coord_max'(r_win[WIN_X_MAX]),
                      t_coord_max'(r_win[WIN_Y_MIN]), t_coord_max'(r_win[WIN_Y_MAX]));

    logic [3:0][N-1:0] r_o_seg;
    logic              r_o_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= ch_valid[4];
        end
        if (en) begin
            r_o_seg <= n_vis ? fs : '0;
            r_o_vis <= n_vis;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_clipped_start_x = r_o_seg[0];
    assign o_clipped_start_y = r_o_seg[1];
    assign o_clipped_end_x   = r_o_seg[2];
    assign o_clipped_end_y   = r_o_seg[3];
    assign o_visible         = r_o_vis;

    // A frozen pipeline must come from a held output beat.
    `SWC_ASSERT_CLK(a_stall_src, o_stall |-> (o_valid && i_stall), "stall without held beat")
    // An invisible beat carries all-zero endpoints.
    `SWC_ASSERT_CLK(a_invis_zero, (o_valid && !o_visible) |-> (r_o_seg == '0),
                    "invisible beat has nonzero endpoints")
    // A visible beat has at least one endpoint inside the current window.
    `SWC_ASSERT_CLK(a_vis_inside, (o_valid && o_visible) |->
        (swc_in_window(t_coord_max'(r_o_seg[0]), t_coord_max'(r_o_seg[1]),
                       t_coord_max'(r_win[WIN_X_MIN]), t_coord_max'(r_win[WIN_X_MAX]),
                       t_coord_max'(r_win[WIN_Y_MIN]), t_coord_max'(r_win[WIN_Y_MAX])) ||
         swc_in_window(t_coord_max'(r_o_seg[2]), t_coord_max'(r_o_seg[3]),
                       t_coord_max'(r_win[WIN_X_MIN]), t_coord_max'(r_win[WIN_X_MAX]),
                       t_coord_max'(r_win[WIN_Y_MIN]), t_coord_max'(r_win[WIN_Y_MAX]))),
        "visible beat with both endpoints outside")
    // The output valid comes out of reset low.
    `SWC_ASSERT_ALWAYS(a_rst_valid, !i_rst_n |=> !o_valid, "valid high after reset")

endmodule
